FILE: rtl/sobel_pkg.sv
package sobel_pkg;

   localparam int PIX_W    = 8;
   localparam int CSR_W    = 12;
   localparam int CSR_IDX_W = 1;
   localparam int SUM_W    = 10;
   localparam int SQ_W     = 21;
   localparam int ROOT_W   = 8;
   localparam int BIT_IDX_W = 3;

   localparam logic [CSR_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CSR_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [CSR_W-1:0] MIN_DIM      = 12'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAD,
      ST_SQUARE,
      ST_ROOT,
      ST_OUT
   } st_type;

endpackage

FILE: rtl/sobel_edge_magnitude_top.sv
// One pixel at a time: req_ready is high only in the idle state, so a new pixel
// waits until the last has left the gradient step (border) or the 8-step square
// root iteration and the output step (interior); a result held by rsp_ready low
// stalls the next interior result in the output step, and new requests behind it.
// Reset (synchronous, active high) clears the counters, the handshake state and
// loads frame_width 640 and frame_height 480; the line store is not cleared.
module sobel_edge_magnitude_top #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sobel_pkg::PIX_W-1:0]   req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sobel_pkg::PIX_W-1:0]   rsp_edge_res,
   output logic                          rsp_frame_last,
   input  logic                          csr_wr_en,
   input  logic [sobel_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sobel_pkg::CSR_W-1:0]   csr_wr_data
);

   import sobel_pkg::*;

   localparam int AW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CW = ($clog2(MAX_WIDTH + 1) > CSR_W) ? $clog2(MAX_WIDTH + 1) : CSR_W;
   localparam int RW = 2 * PIX_W;

   st_type               state_ff, state_in;
   logic [CSR_W-1:0]     fw_ff, fw_in;
   logic [CSR_W-1:0]     fh_ff, fh_in;
   logic [AW-1:0]        col_ff, col_in;
   logic [CSR_W-1:0]     row_ff, row_in;
   logic [PIX_W-1:0]     pix_ff, pix_in;
   logic [PIX_W-1:0]     win_ff [6];
   logic [PIX_W-1:0]     win_in [6];
   logic [SUM_W-1:0]     gx_ff, gx_in;
   logic [SUM_W-1:0]     gy_ff, gy_in;
   logic                 last_ff, last_in;
   logic [SQ_W-1:0]      sq_ff, sq_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]     res_ff, res_in;
   logic                 rlast_ff, rlast_in;

   logic [CW-1:0]        fw_ext;
   logic [CW-1:0]        eff_w;
   logic [CSR_W-1:0]     eff_h;
   logic                 col_last;
   logic                 row_last;
   logic                 req_acc;
   logic                 ram_we;
   logic [RW-1:0]        ram_rd;
   logic [PIX_W-1:0]     top_px;
   logic [PIX_W-1:0]     mid_px;
   logic [SUM_W-1:0]     sum_right;
   logic [SUM_W-1:0]     sum_left;
   logic [SUM_W-1:0]     sum_low;
   logic [SUM_W-1:0]     sum_high;
   logic signed [SUM_W:0] dx;
   logic signed [SUM_W:0] dy;
   logic [2*SUM_W-1:0]   gx_sq;
   logic [2*SUM_W-1:0]   gy_sq;
   logic [ROOT_W-1:0]    trial;
   logic [2*ROOT_W-1:0]  trial_sq;

   assign fw_ext   = CW'(fw_ff);
   assign eff_w    = (fw_ext < CW'(MIN_DIM)) ? CW'(MIN_DIM) :
                     ((fw_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : fw_ext);
   assign eff_h    = (fh_ff < MIN_DIM) ? MIN_DIM : fh_ff;
   assign col_last = (CW'(col_ff) == (eff_w - CW'(1)));
   assign row_last = (row_ff == (eff_h - CSR_W'(1)));

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid & req_ready;

   assign top_px = ram_rd[RW-1:PIX_W];
   assign mid_px = ram_rd[PIX_W-1:0];

   assign sum_right = SUM_W'(top_px) + SUM_W'({mid_px, 1'b0}) + SUM_W'(pix_ff);
   assign sum_left  = SUM_W'(win_ff[0]) + SUM_W'({win_ff[1], 1'b0}) + SUM_W'(win_ff[2]);
   assign sum_low   = SUM_W'(win_ff[2]) + SUM_W'({win_ff[5], 1'b0}) + SUM_W'(pix_ff);
   assign sum_high  = SUM_W'(win_ff[0]) + SUM_W'({win_ff[3], 1'b0}) + SUM_W'(top_px);
   assign dx = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
   assign dy = $signed({1'b0, sum_low}) - $signed({1'b0, sum_high});

   assign gx_sq = (2*SUM_W)'(gx_ff) * (2*SUM_W)'(gx_ff);
   assign gy_sq = (2*SUM_W)'(gy_ff) * (2*SUM_W)'(gy_ff);

   assign trial    = root_ff | (ROOT_W'(1) << bit_ff);
   assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

   sobel_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_ff),
      .wr_data ({mid_px, pix_ff}),
      .rd_en   (req_acc),
      .rd_addr (col_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      pix_in       = pix_ff;
      win_in       = win_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      res_in       = res_ff;
      rlast_in     = rlast_ff;
      ram_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in   = req_pixel;
               state_in = ST_GRAD;
            end
         end
         ST_GRAD: begin
            ram_we    = 1'b1;
            win_in[0] = win_ff[3];
            win_in[1] = win_ff[4];
            win_in[2] = win_ff[5];
            win_in[3] = top_px;
            win_in[4] = mid_px;
            win_in[5] = pix_ff;
            gx_in     = dx[SUM_W] ? SUM_W'(-dx) : dx[SUM_W-1:0];
            gy_in     = dy[SUM_W] ? SUM_W'(-dy) : dy[SUM_W-1:0];
            last_in   = row_last & col_last;
            if (col_last) begin
               col_in = '0;
               row_in = row_last ? '0 : row_ff + CSR_W'(1);
            end else begin
               col_in = col_ff + AW'(1);
            end
            if (row_ff >= CSR_W'(2) && col_ff >= AW'(2)) begin
               state_in = ST_SQUARE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            sq_in    = SQ_W'(gx_sq) + SQ_W'(gy_sq);
            root_in  = '0;
            bit_in   = BIT_IDX_W'(ROOT_W - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (SQ_W'(trial_sq) <= sq_ff) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               bit_in = bit_ff - BIT_IDX_W'(1);
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               res_in       = root_ff;
               rlast_in     = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // restart the frame on any register write
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_FRAME_WIDTH:  fw_in = csr_wr_data;
            CSR_FRAME_HEIGHT: fh_in = csr_wr_data;
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fw_ff        <= WIDTH_RESET;
         fh_ff        <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff   <= pix_in;
      win_ff   <= win_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      last_ff  <= last_in;
      sq_ff    <= sq_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
      res_ff   <= res_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = res_ff;
   assign rsp_frame_last = rlast_ff;

`ifndef SYNTH
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      CW'(col_ff) < eff_w)
      else $error("column counter beyond effective width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_ff < eff_h)
      else $error("row counter beyond effective height");

   a_accept_to_grad: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_GRAD)
      else $error("accepted request did not enter gradient step");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && bit_ff == '0) |=> state_ff == ST_OUT)
      else $error("root iteration did not finish after last bit");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into output register");
`endif

endmodule

FILE: rtl/sobel_ram.sv
module sobel_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: dv/sobel_edge_magnitude_top_tb.sv
`timescale 1ns / 100ps

module sobel_edge_magnitude_top_tb;
   import sobel_pkg::*;

   localparam int MAX_W        = 2048;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_MAX   = 10;
   localparam int NUM_ROWS     = 23;
   localparam int NUM_PHASES   = 9;

   typedef struct packed {
      logic [PIX_W-1:0] mag;
      logic             last;
   } mag_result_type;

   typedef struct packed {
      logic             is_csr;
      csr_idx_type      idx;
      logic [CSR_W-1:0] value;
      logic [PIX_W-1:0] pixel;
      logic             known;
      logic [PIX_W-1:0] mag;
      logic             last;
   } stim_row_type;

   typedef struct {
      int width;
      int height;
      int count;
      int tx_pct;
      int rx_pct;
      bit hold;
      bit pause;
   } phase_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_ready;
   logic [PIX_W-1:0]     req_pixel   = '0;
   logic                 rsp_valid;
   logic                 rsp_ready   = 1'b0;
   logic [PIX_W-1:0]     rsp_edge_res;
   logic                 rsp_frame_last;
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [CSR_W-1:0]     csr_wr_data = '0;

   logic [CSR_W-1:0] frame_w = WIDTH_RESET;
   logic [CSR_W-1:0] frame_h = HEIGHT_RESET;
   logic [PIX_W-1:0] two_above [MAX_W];
   logic [PIX_W-1:0] one_above [MAX_W];
   logic [PIX_W-1:0] win [6];
   int               col_pos = 0;
   int               row_pos = 0;

   mag_result_type pending_mags [$];
   int             fail_count   = 0;
   int             cycle_count  = 0;
   int             tx_idle_pct  = 0;
   int             rx_stall_pct = 0;
   int             hold_left    = 0;
   bit             rx_hold_req  = 1'b0;

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h5A, 1'b0, 8'h00, 1'b0},
      '{1'b1, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b1, CSR_FRAME_HEIGHT, 12'd1, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b1, 8'h00, 1'b1},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'h00, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b0, 8'h00, 1'b0},
      '{1'b0, CSR_FRAME_WIDTH,  12'd0, 8'hFF, 1'b1, 8'hFF, 1'b1}
   };

   phase_type phases [NUM_PHASES] = '{
      '{3,    3,    90,  0,  0,  1'b0, 1'b0},
      '{5,    4,    100, 69, 0,  1'b0, 1'b0},
      '{2,    2,    45,  0,  69, 1'b0, 1'b0},
      '{6,    5,    90,  9,  9,  1'b1, 1'b0},
      '{4,    6,    96,  0,  0,  1'b0, 1'b1},
      '{3,    4095, 60,  0,  69, 1'b0, 1'b0},
      '{4095, 3,    30,  0,  0,  1'b0, 1'b0},
      '{8,    3,    60,  69, 0,  1'b1, 1'b0},
      '{10,   0,    30,  9,  9,  1'b0, 1'b1}
   };

   sobel_edge_magnitude_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_frame_last (rsp_frame_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bit sobel_predict(input logic [PIX_W-1:0] pix,
                                        output mag_result_type res);
      int w, h, c, r, top, mid, bot, gx, gy, root;
      int unsigned sq;
      bit hit;
      w = (frame_w < 3) ? 3 : (frame_w > MAX_W) ? MAX_W : int'(frame_w);
      h = (frame_h < 3) ? 3 : int'(frame_h);
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      top = int'(two_above[c]);
      mid = int'(one_above[c]);
      bot = int'(pix);
      hit = (r >= 2) && (c >= 2);
      res = '0;
      if (hit) begin
         gx = (top + 2 * mid + bot) - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
         gy = (int'(win[2]) + 2 * int'(win[5]) + bot) - (int'(win[0]) + 2 * int'(win[3]) + top);
         sq = gx * gx + gy * gy;
         root = 0;
         if (sq >= 65536) root = 255;
         else while ((root + 1) * (root + 1) <= sq) root++;
         res.mag  = PIX_W'(root);
         res.last = (r == h - 1) && (c == w - 1);
      end
      two_above[c] = PIX_W'(mid);
      one_above[c] = pix;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = PIX_W'(top);
      win[4] = PIX_W'(mid);
      win[5] = pix;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      return hit;
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic known,
                             input mag_result_type known_res);
      mag_result_type res;
      bit hit;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      do @(posedge clock); while (!req_ready);
      hit = sobel_predict(pix, res);
      if (known) pending_mags.push_back(known_res);
      else if (hit) pending_mags.push_back(res);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_mags.size() != 0);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_W-1:0] value);
      wait_drained();
      // drain border pixels still in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) frame_w = value;
      else frame_h = value;
      col_pos = 0;
      row_pos = 0;
   endtask

   always @(posedge clock) begin
      mag_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_mags.size() == 0) begin
            if (fail_count < REPORT_MAX)
               $display("unexpected result: edge_res %0d frame_last %0d",
                        rsp_edge_res, rsp_frame_last);
            fail_count++;
         end else begin
            exp_res = pending_mags.pop_front();
            if (rsp_edge_res !== exp_res.mag || rsp_frame_last !== exp_res.last) begin
               if (fail_count < REPORT_MAX)
                  $display("mismatch: expected edge_res %0d frame_last %0d, got %0d %0d",
                           exp_res.mag, exp_res.last, rsp_edge_res, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (rx_hold_req) begin
         rx_hold_req = 1'b0;
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   initial begin
      int prev;
      int pix;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr)
            write_csr(directed_rows[i].idx, directed_rows[i].value);
         else
            send_pixel(directed_rows[i].pixel, directed_rows[i].known,
                       {directed_rows[i].mag, directed_rows[i].last});
      end
      foreach (phases[p]) begin
         write_csr(CSR_FRAME_WIDTH, CSR_W'(phases[p].width));
         write_csr(CSR_FRAME_HEIGHT, CSR_W'(phases[p].height));
         tx_idle_pct  = phases[p].tx_pct;
         rx_stall_pct = phases[p].rx_pct;
         if (phases[p].hold) rx_hold_req = 1'b1;
         prev = $urandom_range(255);
         for (int n = 0; n < phases[p].count; n++) begin
            if (phases[p].pause && n == phases[p].count / 2) wait_drained();
            case ($urandom_range(2))
               0: pix = $urandom_range(255);
               1: pix = $urandom_range(1) ? 255 : 0;
               default: pix = prev + int'($urandom_range(16)) - 8;
            endcase
            if (pix < 0) pix = 0;
            if (pix > 255) pix = 255;
            prev = pix;
            send_pixel(PIX_W'(pix), 1'b0, '0);
         end
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_mags.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
